@@ rtl/tca_pkg.sv @@
// Shared types and constants for the tone channel allocator.
// No dependencies.
package tca_pkg;

   localparam int MAX_RESULTS = 8;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_COMMIT = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] freq;
      logic [15:0] duration;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  channel;
      logic [15:0] tone;
      logic        accepted;
      logic [3:0]  active_count;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMMIT,
      ST_TICK
   } state_type;

   // broadcast to every channel cell
   typedef struct packed {
      logic        place;
      logic        stop;
      logic [31:0] deadline;
   } chan_cmd_type;

   typedef struct packed {
      logic active;
      logic expired;
      logic grant_hi;
      logic grant_lo;
   } chan_stat_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [15:0] len;
   } pend_entry_type;

endpackage

@@ rtl/tca_chan_cell.sv @@
// One tone channel: active flag, deadline, expiry test and the two priority chains.
// Depends on tca_pkg.
module tca_chan_cell import tca_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [31:0]   time_now,
   input  chan_cmd_type  cmd,
   input  logic          hi_in,
   input  logic          lo_in,
   output logic          hi_out,
   output logic          lo_out,
   output chan_stat_type stat
);

   logic        active_ff, active_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [31:0] elapsed;
   logic        expired;

   // deadline passed when the modular difference is in the lower half
   assign elapsed = time_now - deadline_ff;
   assign expired = active_ff && !elapsed[31];

   // hi chain runs from the top channel down: first free channel wins
   assign hi_out = hi_in | !active_ff;
   // lo chain runs from channel zero up: first expired channel wins
   assign lo_out = lo_in | expired;

   assign stat.active   = active_ff;
   assign stat.expired  = expired;
   assign stat.grant_hi = !active_ff && !hi_in;
   assign stat.grant_lo = expired && !lo_in;

   always_comb begin
      active_in   = active_ff;
      deadline_in = deadline_ff;
      if (cmd.place && stat.grant_hi) begin
         active_in   = 1'b1;
         deadline_in = cmd.deadline;
      end else if (cmd.stop && stat.grant_lo) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
   end

endmodule

@@ rtl/tca_pend_cell.sv @@
// One slot of the pending beep queue; shifts toward the head on pop.
// Depends on tca_pkg.
module tca_pend_cell import tca_pkg::*; (
   input  logic           clock,
   input  logic           load,
   input  logic           shift,
   input  pend_entry_type new_entry,
   input  pend_entry_type nb_entry,
   output pend_entry_type entry
);

   pend_entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = new_entry;
      end else if (shift) begin
         entry_in = nb_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/tone_channel_allocator_core.sv @@
// Tone channel allocator: row of channel cells, row of pending cells, sequencer.
// Add and unused actions: one result in the cycle after accept, busy stays low.
// Commit: busy while beeps are placed, one result per cycle; the first result passes
// through state_ff and then rsp_strobe_ff; tick likewise with channels stopped. Rate set
// by the one-result-per-cycle walk. Synchronous reset clears control state and channels.
// Depends on tca_pkg, tca_chan_cell, tca_pend_cell.
module tone_channel_allocator_core import tca_pkg::*; #(
   parameter int CHANNELS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CntW  = $clog2(CHANNELS + 1);
   localparam int ChanW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   state_type      state_ff, state_in;
   logic [CntW-1:0] pcount_ff, pcount_in;
   logic [CntW-1:0] act_ff, act_in;
   logic [CntW-1:0] evt_ff, evt_in;
   logic [31:0]    time_ff, time_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_type        rsp_ff, rsp_in;

   chan_cmd_type   cmd;
   chan_stat_type  stat [CHANNELS];
   logic [CHANNELS:0] hi_chain, lo_chain;
   logic [CHANNELS-1:0] active_vec, free_vec, exp_vec, ghi_vec, glo_vec;
   logic [ChanW-1:0] hi_idx, lo_idx;
   logic           any_free, any_exp, free_after, exp_after;

   pend_entry_type pend [CHANNELS];
   pend_entry_type new_entry;
   logic           pend_wr, pend_pop;
   logic           accept, report, final_evt;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign hi_chain[CHANNELS] = 1'b0;
   assign lo_chain[0]        = 1'b0;

   genvar g;
   generate
      for (g = 0; g < CHANNELS; g++) begin : g_chan
         tca_chan_cell u_chan (
            .clock    (clock),
            .reset    (reset),
            .time_now (time_ff),
            .cmd      (cmd),
            .hi_in    (hi_chain[g+1]),
            .lo_in    (lo_chain[g]),
            .hi_out   (hi_chain[g]),
            .lo_out   (lo_chain[g+1]),
            .stat     (stat[g])
         );
         assign active_vec[g] = stat[g].active;
         assign free_vec[g]   = !stat[g].active;
         assign exp_vec[g]    = stat[g].expired;
         assign ghi_vec[g]    = stat[g].grant_hi;
         assign glo_vec[g]    = stat[g].grant_lo;

         if (g == CHANNELS - 1) begin : g_tail
            tca_pend_cell u_pend (
               .clock     (clock),
               .load      (pend_wr && (pcount_ff == CntW'(g))),
               .shift     (pend_pop),
               .new_entry (new_entry),
               .nb_entry  (pend[g]),
               .entry     (pend[g])
            );
         end else begin : g_body
            tca_pend_cell u_pend (
               .clock     (clock),
               .load      (pend_wr && (pcount_ff == CntW'(g))),
               .shift     (pend_pop),
               .new_entry (new_entry),
               .nb_entry  (pend[g+1]),
               .entry     (pend[g])
            );
         end
      end
   endgenerate

   assign any_free   = hi_chain[0];
   assign any_exp    = lo_chain[CHANNELS];
   assign free_after = |(free_vec & ~ghi_vec);
   assign exp_after  = |(exp_vec & ~glo_vec);

   always_comb begin
      hi_idx = '0;
      lo_idx = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (ghi_vec[i]) hi_idx |= ChanW'(i);
         if (glo_vec[i]) lo_idx |= ChanW'(i);
      end
   end

   assign new_entry.freq = req_item.freq;
   assign new_entry.len  = req_item.duration;

   // events past the result budget still act but are not reported
   assign report = (int'(evt_ff) < MAX_RESULTS);

   always_comb begin
      state_in      = state_ff;
      pcount_in     = pcount_ff;
      act_in        = act_ff;
      evt_in        = evt_ff;
      time_in       = time_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rsp_in.active_count = 4'(act_ff);
      cmd.place     = 1'b0;
      cmd.stop      = 1'b0;
      cmd.deadline  = time_ff + {16'd0, pend[0].len};
      pend_wr       = 1'b0;
      pend_pop      = 1'b0;
      final_evt     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               evt_in = '0;
               case (req_item.action)
                  ACT_ADD: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.last   = 1'b1;
                     if (pcount_ff != CntW'(CHANNELS)) begin
                        pend_wr         = 1'b1;
                        pcount_in       = pcount_ff + 1'b1;
                        rsp_in.accepted = 1'b1;
                     end
                  end
                  ACT_COMMIT: begin
                     state_in = ST_COMMIT;
                  end
                  ACT_TICK: begin
                     time_in  = time_ff + 32'd1;
                     state_in = ST_TICK;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.last   = 1'b1;
                  end
               endcase
            end
         end
         ST_COMMIT: begin
            if (pcount_ff != '0 && any_free) begin
               cmd.place  = 1'b1;
               pend_pop   = 1'b1;
               act_in     = act_ff + 1'b1;
               evt_in     = evt_ff + 1'b1;
               final_evt  = (pcount_ff == CntW'(1)) || !free_after;
               pcount_in  = final_evt ? '0 : pcount_ff - 1'b1;
               rsp_strobe_in       = report;
               rsp_in.kind         = KIND_START;
               rsp_in.channel      = 3'(hi_idx);
               rsp_in.tone         = pend[0].freq;
               rsp_in.active_count = 4'(act_in);
               rsp_in.last         = final_evt || (int'(evt_ff) == MAX_RESULTS - 1);
            end else begin
               // nothing placed at all: plain acknowledge, drop the list
               final_evt     = 1'b1;
               pcount_in     = '0;
               rsp_strobe_in = 1'b1;
               rsp_in.last   = 1'b1;
            end
            if (final_evt) state_in = ST_IDLE;
         end
         ST_TICK: begin
            if (any_exp) begin
               cmd.stop   = 1'b1;
               act_in     = act_ff - 1'b1;
               evt_in     = evt_ff + 1'b1;
               final_evt  = !exp_after;
               rsp_strobe_in       = report;
               rsp_in.kind         = KIND_STOP;
               rsp_in.channel      = 3'(lo_idx);
               rsp_in.active_count = 4'(act_in);
               rsp_in.last         = final_evt || (int'(evt_ff) == MAX_RESULTS - 1);
            end else begin
               final_evt     = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_in.last   = 1'b1;
            end
            if (final_evt) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pcount_ff     <= '0;
         act_ff        <= '0;
         evt_ff        <= '0;
         time_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pcount_ff     <= pcount_in;
         act_ff        <= act_in;
         evt_ff        <= evt_in;
         time_ff       <= time_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // running count must track the channel flags
   a_act_count: assert property (@(posedge clock) disable iff (reset)
      act_ff == CntW'($countones(active_vec)))
      else $error("active count out of step with channel flags");

   a_pcount_range: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= CntW'(CHANNELS))
      else $error("pending count beyond queue depth");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.action != ACT_COMMIT && req_item.action != ACT_TICK)
      |=> (rsp_strobe && rsp_item.last && !busy))
      else $error("single-result item did not produce a final result");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && (CHANNELS <= MAX_RESULTS)) |-> (rsp_strobe && rsp_item.last))
      else $error("walk ended without a final result");

endmodule

@@ bench/tca_checker.sv @@
// Checker for the tone channel allocator: watches the item and result channels,
// predicts the results of each accepted item and compares them in order.
// Depends on tca_pkg.
module tca_checker import tca_pkg::*; #(
   parameter int CHANNELS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      outstanding,
   output int      starts_seen,
   output int      stops_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] queued_freq [CHANNELS];
   logic [15:0] queued_len [CHANNELS];
   int unsigned queued_count;
   logic        sounding [CHANNELS];
   logic [31:0] stop_tick [CHANNELS];
   logic [31:0] tick_now;
   rsp_type     expected_rsps [$];

   function automatic int unsigned count_sounding();
      int unsigned n;
      n = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (sounding[i]) n++;
      end
      return n;
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] kind, int unsigned chan,
                                        logic [15:0] tone, logic acc, int unsigned act);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.channel = chan[2:0];
      r.tone = tone;
      r.accepted = acc;
      r.active_count = act[3:0];
      return r;
   endfunction

   // works out every result of one item and updates the predicted state
   task automatic predict_item(input req_type item);
      rsp_type     outs [$];
      int unsigned act;
      int          c;
      logic [31:0] age;
      act = count_sounding();
      case (item.action)
         ACT_ADD: begin
            if (queued_count < CHANNELS) begin
               queued_freq[queued_count] = item.freq;
               queued_len[queued_count] = item.duration;
               queued_count++;
               outs.push_back(make_rsp(KIND_ACK, 0, '0, 1'b1, act));
            end else begin
               outs.push_back(make_rsp(KIND_ACK, 0, '0, 1'b0, act));
            end
         end
         ACT_COMMIT: begin
            for (int k = 0; k < queued_count; k++) begin
               c = CHANNELS - 1;
               while (c >= 0 && sounding[c]) c--;
               if (c >= 0) begin
                  sounding[c] = 1'b1;
                  stop_tick[c] = tick_now + {16'd0, queued_len[k]};
                  act++;
                  outs.push_back(make_rsp(KIND_START, c, queued_freq[k], 1'b0, act));
               end
            end
            queued_count = 0;
         end
         ACT_TICK: begin
            tick_now = tick_now + 32'd1;
            for (int i = 0; i < CHANNELS; i++) begin
               age = tick_now - stop_tick[i];
               // deadline passed when the modular distance is non-negative
               if (sounding[i] && !age[31]) begin
                  sounding[i] = 1'b0;
                  act--;
                  outs.push_back(make_rsp(KIND_STOP, i, '0, 1'b0, act));
               end
            end
         end
         default: ;
      endcase
      if (outs.size() == 0) outs.push_back(make_rsp(KIND_ACK, 0, '0, 1'b0, act));
      // events past the result budget take effect but are not reported
      while (outs.size() > MAX_RESULTS) void'(outs.pop_back());
      outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) expected_rsps.push_back(outs[i]);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         queued_count = 0;
         tick_now = '0;
         for (int i = 0; i < CHANNELS; i++) begin
            sounding[i] = 1'b0;
            stop_tick[i] = '0;
         end
         expected_rsps.delete();
         fail_count = 0;
         starts_seen = 0;
         stops_seen = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got %p", $time, rsp_item);
            end else begin
               want = expected_rsps.pop_front();
               check_field("kind", want.kind, rsp_item.kind);
               check_field("channel", want.channel, rsp_item.channel);
               check_field("tone", want.tone, rsp_item.tone);
               check_field("accepted", want.accepted, rsp_item.accepted);
               check_field("active_count", want.active_count, rsp_item.active_count);
               check_field("last", want.last, rsp_item.last);
               if (want.kind == KIND_START) starts_seen++;
               if (want.kind == KIND_STOP) stops_seen++;
            end
         end
         if (start && !busy) predict_item(req_item);
      end
      outstanding = expected_rsps.size();
   end

endmodule

@@ bench/testbench.sv @@
// Top of the tone channel allocator bench: clock, reset, item stimulus and verdict.
// Depends on tca_pkg, tone_channel_allocator_core and tca_checker.
module testbench;
   import tca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CHANNELS   = 8;
   localparam int         ITEM_GOAL  = 320;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      fail_count;
   int      outstanding;
   int      starts_seen;
   int      stops_seen;

   req_type beep_plan [$];
   int      items_sent = 0;
   int      adds_sent = 0;
   int      commits_sent = 0;
   int      ticks_sent = 0;
   int      unused_sent = 0;

   always #5 clock = ~clock;

   tone_channel_allocator_core #(.CHANNELS(CHANNELS)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   tca_checker #(.CHANNELS(CHANNELS)) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .fail_count(fail_count),
      .outstanding(outstanding),
      .starts_seen(starts_seen),
      .stops_seen(stops_seen)
   );

   function automatic req_type make_req(logic [1:0] action, logic [15:0] freq,
                                        logic [15:0] duration);
      req_type r;
      r.action = action;
      r.freq = freq;
      r.duration = duration;
      return r;
   endfunction

   // mostly short beeps so channels free up; long ones hold a channel for good
   function automatic logic [15:0] pick_len();
      int unsigned r;
      r = $urandom_range(0, 79);
      if (r == 0) return 16'($urandom);
      if (r < 8) return 16'd0;
      return 16'($urandom_range(1, 15));
   endfunction

   task automatic plan_round();
      int unsigned kind;
      int unsigned n;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) beep_plan.push_back(make_req(2'($urandom_range(0, 3)),
                                                 16'($urandom), 16'($urandom)));
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) beep_plan.push_back(make_req(ACT_ADD, 16'($urandom), pick_len()));
         // now and then leave the list uncommitted so it fills across rounds
         if (kind != 1) begin
            beep_plan.push_back(make_req(ACT_COMMIT, 16'($urandom), 16'($urandom)));
         end
         n = $urandom_range(0, 10);
         repeat (n) beep_plan.push_back(make_req(ACT_TICK, 16'($urandom), 16'($urandom)));
      end
   endtask

   task automatic send_item(input req_type item);
      req_item <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      case (item.action)
         ACT_ADD:    adds_sent++;
         ACT_COMMIT: commits_sent++;
         ACT_TICK:   ticks_sent++;
         default:    unused_sent++;
      endcase
      if (item.action != ACT_UNUSED) items_sent++;
   endtask

   task automatic idle(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin
      int unsigned burst_left;
      int unsigned gap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the list with a zero and a maximal beep, overflow it, commit,
      // then a commit with every channel busy, unused action, empty commit
      beep_plan.push_back(make_req(ACT_ADD, 16'h0000, 16'h0000));
      beep_plan.push_back(make_req(ACT_ADD, 16'hFFFF, 16'hFFFF));
      for (int i = 1; i <= 6; i++) begin
         beep_plan.push_back(make_req(ACT_ADD, i[0] ? 16'h5555 : 16'hAAAA, i[15:0]));
      end
      beep_plan.push_back(make_req(ACT_ADD, 16'hBEEF, 16'h0002));
      beep_plan.push_back(make_req(ACT_COMMIT, 16'h0000, 16'h0000));
      beep_plan.push_back(make_req(ACT_ADD, 16'h1234, 16'h0003));
      beep_plan.push_back(make_req(ACT_COMMIT, 16'hFFFF, 16'hFFFF));
      beep_plan.push_back(make_req(ACT_UNUSED, 16'hFFFF, 16'hFFFF));
      beep_plan.push_back(make_req(ACT_COMMIT, 16'h0000, 16'h0000));
      repeat (8) beep_plan.push_back(make_req(ACT_TICK, 16'h0000, 16'h0000));
      while (beep_plan.size() != 0) send_item(beep_plan.pop_front());
      drain();

      burst_left = 0;
      while (items_sent < ITEM_GOAL) begin
         if (beep_plan.size() == 0) plan_round();
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) idle(gap);
            burst_left = $urandom_range(1, 12);
         end
         send_item(beep_plan.pop_front());
         burst_left--;
         if (items_sent % 60 == 0) begin
            drain();
            burst_left = 0;
         end
      end
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);

      $display("Sent %0d adds, %0d commits, %0d ticks and %0d unused actions;",
               adds_sent, commits_sent, ticks_sent, unused_sent);
      $display("checked %0d channel starts and %0d channel stops.", starts_seen, stops_seen);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
